[sv/lpn_pkg.sv]
// shared types and constants for the lexical path normalizer
// used by lpn_ctrl, lpn_datapath and lexical_path_normalizer; no dependencies
package lpn_pkg;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_FETCH  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;   // no operation, ignored

   // how a fetch gets its byte
   localparam logic [1:0] FK_EMIT = 2'd0;   // answer known at once
   localparam logic [1:0] FK_RAW  = 2'd1;   // raw store read, pass-through
   localparam logic [1:0] FK_SEG  = 2'd2;   // segment stack read first

   typedef struct packed {
      logic latch;     // capture the request byte
      logic clear;     // start a new path
      logic app;       // append step
      logic app_fix;   // reload top cumulative length after a pop
      logic fin1;      // close pending segment
      logic fin2;      // compute final length, post status
      logic fet1;      // fetch: classify
      logic fet2;      // fetch: segment entry in hand
      logic fet3;      // fetch: raw byte in hand
   } cmd_type;

   typedef struct packed {
      logic       done;
      logic       rsp_busy;
      logic       pop_rd;
      logic [1:0] fet_kind;
      logic       seg_slash;
   } status_type;

endpackage

[sv/lexical_path_normalizer.sv]
// top level of the lexical path normalizer
// instantiates lpn_ctrl and lpn_datapath; depends on lpn_pkg
//
// usage: the req channel carries one transaction per operation. req_tuser is
// the opcode (append a path byte, finish the path, fetch the next result
// byte) and req_tdata the path byte. appends give no response. a finish
// gives one status transaction on rsp; each fetch after a finish gives one
// byte transaction. a fetch while a path is still loading is dropped.
// an append latches the byte and runs the append step, with a fix step when a
// '..' segment pops the stack and the new top entry is read back from the
// segment memory. a finish closes the pending segment, then posts the status.
// a fetch waits on the registered reads of the segment stack and raw store.
// one operation is in flight at a time; the response sits in an output
// register, and req_tready stays low while it is not yet taken, so a stall
// on rsp holds off the next request without losing anything.
// reset clears the loader to an empty path; the byte store and segment
// stack need no clearing, as only written entries are ever read.
module lexical_path_normalizer #(
   parameter int IN_BYTES     = 512,
   parameter int OUT_BYTES    = 512,
   parameter int MAX_SEGMENTS = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // path_byte
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_length[9:0], passed_through[10], input_overflow[11],
   // result_byte[19:12], past_end[20], zero fill[23:21]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // is_last_byte
);
   import lpn_pkg::*;

   cmd_type    cmd;
   status_type st;

   // sequencer: accepts a transaction and steps the datapath
   lpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   // storage, segment tracking and response register
   lpn_datapath #(
      .IN_BYTES     (IN_BYTES),
      .OUT_BYTES    (OUT_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sv/lpn_ctrl.sv]
// controller state machine of the lexical path normalizer
// depends on lpn_pkg for the command and status structs
module lpn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_opcode,
   input  lpn_pkg::status_type st,
   output lpn_pkg::cmd_type    cmd
);
   import lpn_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_APP  = 3'd1;
   localparam logic [2:0] S_FIX  = 3'd2;
   localparam logic [2:0] S_FIN1 = 3'd3;
   localparam logic [2:0] S_FIN2 = 3'd4;
   localparam logic [2:0] S_FET1 = 3'd5;
   localparam logic [2:0] S_FET2 = 3'd6;
   localparam logic [2:0] S_FET3 = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && !st.rsp_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               case (req_opcode)
                  OP_APPEND: begin
                     cmd.clear = st.done;
                     state_in  = S_APP;
                  end
                  OP_FINISH: state_in = S_FIN1;
                  OP_FETCH:  state_in = st.done ? S_FET1 : S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_APP: begin
            cmd.app  = 1'b1;
            state_in = st.pop_rd ? S_FIX : S_IDLE;
         end
         S_FIX: begin
            cmd.app_fix = 1'b1;
            state_in    = S_IDLE;
         end
         S_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = S_IDLE;
         end
         S_FET1: begin
            cmd.fet1 = 1'b1;
            case (st.fet_kind)
               FK_RAW:  state_in = S_FET3;
               FK_SEG:  state_in = S_FET2;
               default: state_in = S_IDLE;
            endcase
         end
         S_FET2: begin
            cmd.fet2 = 1'b1;
            state_in = st.seg_slash ? S_IDLE : S_FET3;
         end
         S_FET3: begin
            cmd.fet3 = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/lpn_datapath.sv]
// datapath of the lexical path normalizer: raw byte store, segment stack,
// loader and fetch registers and the result register; depends on lpn_pkg
module lpn_datapath #(
   parameter int IN_BYTES     = 512,
   parameter int OUT_BYTES    = 512,
   parameter int MAX_SEGMENTS = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_byte,
   input  lpn_pkg::cmd_type    cmd,
   output lpn_pkg::status_type st,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);
   import lpn_pkg::*;

   localparam int AW     = $clog2(IN_BYTES);
   localparam int LW     = $clog2(IN_BYTES + 1);
   localparam int NW     = $clog2(MAX_SEGMENTS + 1);
   localparam int SIW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int MAXLEN = (IN_BYTES > OUT_BYTES) ? IN_BYTES : OUT_BYTES;
   localparam int RW     = $clog2(MAXLEN + 1);

   // memories
   logic [7:0]    raw_mem [IN_BYTES];
   logic [AW-1:0] stk_start_mem [MAX_SEGMENTS];
   logic [LW-1:0] stk_len_mem [MAX_SEGMENTS];
   logic [LW-1:0] stk_cum_mem [MAX_SEGMENTS];
   logic [7:0]    raw_rd_ff;
   logic [AW-1:0] stk_start_rd_ff;
   logic [LW-1:0] stk_len_rd_ff;
   logic [LW-1:0] stk_cum_rd_ff;

   // loader state
   logic [7:0]    byte_ff;
   logic [LW-1:0] len_ff;
   logic          ovf_ff, zero_ff, done_ff, need_ff, abs_ff;
   logic [7:0]    prev_ff, f0_ff, f1_ff;
   logic [NW-1:0] n_ff;
   logic [AW-1:0] cur_start_ff;
   logic [LW-1:0] cur_len_ff;
   logic [7:0]    c0_ff, c1_ff;
   logic [LW-1:0] top_cum_ff;

   // finish and fetch state
   logic [NW-1:0] fin_n_ff;
   logic [LW-1:0] fin_cum_ff;
   logic          fin_rd_ff;
   logic [RW-1:0] rlen_ff, emitted_ff;
   logic [SIW-1:0] rd_seg_ff;
   logic [LW-1:0] rd_off_ff;

   // result register
   logic          rv_ff, rkind_ff, rpast_ff, rlast_ff;
   logic [7:0]    rbyte_ff;

   // segment close classification
   logic          seg_dot, seg_dd, push_ok, pop, pop_rd;
   logic [LW-1:0] cum_new;
   logic          is_slash, app_store;
   logic [NW-1:0] n_m2;

   assign seg_dot = (cur_len_ff == LW'(1)) && (c0_ff == CH_DOT);
   assign seg_dd  = (cur_len_ff == LW'(2)) && (c0_ff == CH_DOT) && (c1_ff == CH_DOT);
   assign cum_new = (n_ff == '0) ? cur_len_ff : top_cum_ff + LW'(1) + cur_len_ff;
   assign push_ok = (cur_len_ff != '0) && !seg_dot && !seg_dd
                    && (n_ff < NW'(MAX_SEGMENTS));
   assign pop     = (cur_len_ff != '0) && seg_dd && (n_ff != '0);
   assign pop_rd  = pop && (n_ff >= NW'(2));
   assign n_m2    = n_ff - NW'(2);

   assign is_slash  = (byte_ff == CH_SLASH);
   assign app_store = !zero_ff && (byte_ff != 8'd0) && (len_ff != LW'(IN_BYTES));

   // fetch decisions
   logic          past, emit1, emit2, emit3, emit;
   logic [7:0]    emit_byte;
   logic [1:0]    fet_kind;
   logic          seg_slash;
   logic [RW:0]   total;
   logic [RW-1:0] final_len;
   logic [LW-1:0] fin_cum_sel;

   assign past = (emitted_ff >= rlen_ff);

   always_comb begin
      if (past) begin
         fet_kind = FK_EMIT;
      end else if (!need_ff) begin
         fet_kind = FK_RAW;
      end else if ((fin_n_ff == '0) || (abs_ff && (emitted_ff == '0))) begin
         fet_kind = FK_EMIT;
      end else begin
         fet_kind = FK_SEG;
      end
   end

   assign seg_slash = !(rd_off_ff < stk_len_rd_ff);

   assign emit1 = cmd.fet1 && (fet_kind == FK_EMIT) && !past;
   assign emit2 = cmd.fet2 && seg_slash;
   assign emit3 = cmd.fet3;
   assign emit  = emit1 || emit2 || emit3;

   always_comb begin
      if (emit3) begin
         emit_byte = raw_rd_ff;
      end else if (emit2) begin
         emit_byte = CH_SLASH;
      end else if (abs_ff) begin
         emit_byte = CH_SLASH;
      end else begin
         emit_byte = CH_DOT;
      end
   end

   assign fin_cum_sel = fin_rd_ff ? stk_cum_rd_ff : fin_cum_ff;
   assign total       = (RW + 1)'(fin_cum_sel) + (RW + 1)'(abs_ff);

   always_comb begin
      if (!need_ff) begin
         final_len = RW'(len_ff);
      end else if (fin_n_ff == '0) begin
         final_len = RW'(1);
      end else if (total > (RW + 1)'(OUT_BYTES - 1)) begin
         final_len = RW'(OUT_BYTES - 1);
      end else begin
         final_len = total[RW-1:0];
      end
   end

   // memory ports
   logic          stk_we;
   logic [SIW-1:0] stk_raddr;
   logic [AW-1:0] raw_raddr;
   logic [LW-1:0] seg_pos;

   assign stk_we    = (cmd.app && app_store && is_slash && push_ok) || (cmd.fin1 && push_ok);
   assign stk_raddr = cmd.fet1 ? rd_seg_ff : n_m2[SIW-1:0];
   assign seg_pos   = LW'(stk_start_rd_ff) + rd_off_ff;
   assign raw_raddr = cmd.fet2 ? seg_pos[AW-1:0] : emitted_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.app && app_store) begin
         raw_mem[len_ff[AW-1:0]] <= byte_ff;
      end
      raw_rd_ff <= raw_mem[raw_raddr];
      if (stk_we) begin
         stk_start_mem[n_ff[SIW-1:0]] <= cur_start_ff;
         stk_len_mem[n_ff[SIW-1:0]]   <= cur_len_ff;
         stk_cum_mem[n_ff[SIW-1:0]]   <= cum_new;
      end
      stk_start_rd_ff <= stk_start_mem[stk_raddr];
      stk_len_rd_ff   <= stk_len_mem[stk_raddr];
      stk_cum_rd_ff   <= stk_cum_mem[stk_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= req_byte;
      end
      if (cmd.app && app_store) begin
         if (len_ff == '0) begin
            f0_ff <= byte_ff;
         end
         if (len_ff == LW'(1)) begin
            f1_ff <= byte_ff;
         end
         if (!is_slash) begin
            if (cur_len_ff == '0) begin
               cur_start_ff <= len_ff[AW-1:0];
               c0_ff        <= byte_ff;
            end
            if (cur_len_ff == LW'(1)) begin
               c1_ff <= byte_ff;
            end
         end else if (push_ok) begin
            top_cum_ff <= cum_new;
         end
      end
      if (cmd.app_fix) begin
         top_cum_ff <= stk_cum_rd_ff;
      end
      if (cmd.fin1) begin
         fin_n_ff   <= pop ? n_ff - NW'(1) : (push_ok ? n_ff + NW'(1) : n_ff);
         fin_cum_ff <= push_ok ? cum_new : top_cum_ff;
         fin_rd_ff  <= pop_rd;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         zero_ff    <= 1'b0;
         done_ff    <= 1'b0;
         need_ff    <= 1'b0;
         abs_ff     <= 1'b0;
         prev_ff    <= '0;
         n_ff       <= '0;
         cur_len_ff <= '0;
         rlen_ff    <= '0;
         emitted_ff <= '0;
         rd_seg_ff  <= '0;
         rd_off_ff  <= '0;
         rv_ff      <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) begin
            rv_ff <= 1'b0;
         end
         if (cmd.clear) begin
            len_ff     <= '0;
            ovf_ff     <= 1'b0;
            zero_ff    <= 1'b0;
            done_ff    <= 1'b0;
            need_ff    <= 1'b0;
            abs_ff     <= 1'b0;
            prev_ff    <= '0;
            n_ff       <= '0;
            cur_len_ff <= '0;
            rlen_ff    <= '0;
            emitted_ff <= '0;
         end
         if (cmd.app) begin
            if (zero_ff) begin
               zero_ff <= 1'b1;
            end else if (byte_ff == 8'd0) begin
               zero_ff <= 1'b1;
            end else if (len_ff == LW'(IN_BYTES)) begin
               ovf_ff <= 1'b1;
            end else begin
               len_ff  <= len_ff + LW'(1);
               prev_ff <= byte_ff;
               if (len_ff == '0) begin
                  abs_ff <= is_slash;
               end
               if ((len_ff != '0) && (prev_ff == CH_SLASH)
                   && ((byte_ff == CH_DOT) || is_slash)) begin
                  need_ff <= 1'b1;
               end
               if ((len_ff == LW'(1)) && (f0_ff == CH_DOT) && is_slash) begin
                  need_ff <= 1'b1;
               end
               if ((len_ff == LW'(2)) && (f0_ff == CH_DOT) && (f1_ff == CH_DOT)
                   && is_slash) begin
                  need_ff <= 1'b1;
               end
               if (is_slash) begin
                  cur_len_ff <= '0;
                  if (pop) begin
                     n_ff <= n_ff - NW'(1);
                  end else if (push_ok) begin
                     n_ff <= n_ff + NW'(1);
                  end
               end else begin
                  cur_len_ff <= cur_len_ff + LW'(1);
               end
            end
         end
         if (cmd.fin2) begin
            rlen_ff    <= final_len;
            done_ff    <= 1'b1;
            emitted_ff <= '0;
            rd_seg_ff  <= '0;
            rd_off_ff  <= '0;
            rv_ff      <= 1'b1;
         end
         if (cmd.fet1 && past) begin
            rv_ff <= 1'b1;
         end
         if (cmd.fet2) begin
            if (seg_slash) begin
               rd_seg_ff <= rd_seg_ff + SIW'(1);
               rd_off_ff <= '0;
            end else begin
               rd_off_ff <= rd_off_ff + LW'(1);
            end
         end
         if (emit) begin
            emitted_ff <= emitted_ff + RW'(1);
            rv_ff      <= 1'b1;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.fin2) begin
         rkind_ff <= 1'b0;
         rbyte_ff <= '0;
         rlast_ff <= 1'b0;
         rpast_ff <= 1'b0;
      end else if (cmd.fet1 && past) begin
         rkind_ff <= 1'b1;
         rbyte_ff <= '0;
         rlast_ff <= 1'b0;
         rpast_ff <= 1'b1;
      end else if (emit) begin
         rkind_ff <= 1'b1;
         rbyte_ff <= emit_byte;
         rlast_ff <= (emitted_ff + RW'(1)) == rlen_ff;
         rpast_ff <= 1'b0;
      end
   end

   logic [RW+9:0] rlen_wide;
   assign rlen_wide = {10'd0, rlen_ff};

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {3'd0, rpast_ff, rbyte_ff, ovf_ff, !need_ff, rlen_wide[9:0]};

   assign st.done      = done_ff;
   assign st.rsp_busy  = rv_ff;
   assign st.pop_rd    = app_store && is_slash && pop_rd;
   assign st.fet_kind  = fet_kind;
   assign st.seg_slash = seg_slash;

endmodule

[verif/lpn_checker.sv]
// response checker for the lexical path normalizer: follows req and rsp
// transactions, computes the expected path result and compares each response
// depends on lpn_pkg
module lpn_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);
   import lpn_pkg::*;

   localparam int IN_BYTES  = 512;
   localparam int OUT_BYTES = 512;
   localparam int MAX_SEGS  = 80;

   typedef struct packed {
      logic       kind;
      logic [9:0] length;
      logic       passed;
      logic       ovf;
      logic [7:0] data;
      logic       last;
      logic       past;
   } path_result_type;

   path_result_type expected_results[$];

   logic [7:0] raw_bytes[IN_BYTES];
   logic [7:0] norm_bytes[OUT_BYTES];
   int   raw_len, norm_len, fetched;
   bit   ovf_seen, zero_seen, loading, rebuilt;

   function automatic bit path_needs_rebuild();
      if (raw_len == 0) return 0;
      for (int i = 0; i + 1 < raw_len; i++)
         if (raw_bytes[i] == CH_SLASH &&
             (raw_bytes[i+1] == CH_DOT || raw_bytes[i+1] == CH_SLASH)) return 1;
      if (raw_bytes[0] == CH_DOT) begin
         if (raw_len >= 2 && raw_bytes[1] == CH_SLASH) return 1;
         if (raw_len >= 3 && raw_bytes[1] == CH_DOT && raw_bytes[2] == CH_SLASH) return 1;
      end
      return 0;
   endfunction

   // dot-segment removal into norm_bytes
   task automatic rebuild_path();
      int seg_at[MAX_SEGS];
      int seg_len[MAX_SEGS];
      int p, n, o, room, st, sl;
      bit absolute;
      p = 0; n = 0; o = 0; room = OUT_BYTES;
      absolute = raw_bytes[0] == CH_SLASH;
      while (p < raw_len) begin
         while (p < raw_len && raw_bytes[p] == CH_SLASH) p++;
         if (p >= raw_len) break;
         st = p;
         while (p < raw_len && raw_bytes[p] != CH_SLASH) p++;
         sl = p - st;
         if (sl == 1 && raw_bytes[st] == CH_DOT) begin
         end else if (sl == 2 && raw_bytes[st] == CH_DOT && raw_bytes[st+1] == CH_DOT) begin
            if (n > 0) n--;
         end else if (n < MAX_SEGS) begin
            seg_at[n] = st; seg_len[n] = sl; n++;
         end
      end
      if (absolute && room > 1) begin
         norm_bytes[o++] = CH_SLASH; room--;
      end
      for (int i = 0; i < n && room > 1; i++) begin
         sl = seg_len[i];
         if (i > 0 && room > 1) begin
            norm_bytes[o++] = CH_SLASH; room--;
         end
         if (sl >= room) sl = room - 1;
         for (int k = 0; k < sl; k++) norm_bytes[o+k] = raw_bytes[seg_at[i]+k];
         o += sl; room -= sl;
      end
      if (o == 0) norm_bytes[o++] = absolute ? CH_SLASH : CH_DOT;
      norm_len = o;
   endtask

   function automatic path_result_type make_result(bit kind, logic [7:0] b, bit last,
                                                   bit past);
      path_result_type r;
      r.kind = kind; r.length = norm_len[9:0]; r.passed = !rebuilt;
      r.ovf = ovf_seen; r.data = b; r.last = last; r.past = past;
      return r;
   endfunction

   task automatic path_apply(logic [1:0] op, logic [7:0] b);
      logic [7:0] v;
      case (op)
         OP_APPEND: begin
            if (!loading) begin
               raw_len = 0; ovf_seen = 0; zero_seen = 0; loading = 1;
               rebuilt = 0; norm_len = 0; fetched = 0;
            end
            if (!zero_seen) begin
               if (b == 8'd0) zero_seen = 1;
               else if (raw_len < IN_BYTES) raw_bytes[raw_len++] = b;
               else ovf_seen = 1;
            end
         end
         OP_FINISH: begin
            rebuilt = path_needs_rebuild();
            if (rebuilt) rebuild_path();
            else norm_len = raw_len;
            fetched = 0; loading = 0;
            expected_results.push_back(make_result(0, 8'd0, 0, 0));
         end
         OP_FETCH: begin
            if (!loading) begin
               if (fetched >= norm_len)
                  expected_results.push_back(make_result(1, 8'd0, 0, 1));
               else begin
                  v = rebuilt ? norm_bytes[fetched] : raw_bytes[fetched];
                  fetched++;
                  expected_results.push_back(make_result(1, v, fetched == norm_len, 0));
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      path_result_type want;
      if (reset) begin
         expected_results.delete();
         raw_len = 0; norm_len = 0; fetched = 0;
         ovf_seen = 0; zero_seen = 0; loading = 1; rebuilt = 0;
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0)
               report_mismatch("unexpected response", 1, 0);
            else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.kind) report_mismatch("kind", rsp_tuser, want.kind);
               if (rsp_tdata[9:0] != want.length)
                  report_mismatch("length", rsp_tdata[9:0], want.length);
               if (rsp_tdata[10] != want.passed)
                  report_mismatch("pass-through", rsp_tdata[10], want.passed);
               if (rsp_tdata[11] != want.ovf)
                  report_mismatch("overflow", rsp_tdata[11], want.ovf);
               if (rsp_tdata[19:12] != want.data)
                  report_mismatch("byte", rsp_tdata[19:12], want.data);
               if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
               if (rsp_tdata[20] != want.past)
                  report_mismatch("past end", rsp_tdata[20], want.past);
               if (rsp_tdata[23:21] != 3'd0) report_mismatch("fill", rsp_tdata[23:21], 0);
            end
         end
         // request after response: a finish cannot answer in the same edge
         if (req_tvalid && req_tready) path_apply(req_tuser, req_tdata);
      end
      pending_count = expected_results.size();
   end

endmodule

[verif/testbench.sv]
// stimulus top for the lexical path normalizer: drives paths, finishes and
// fetches with random gaps and stalls; depends on lpn_pkg, lpn_checker and the rtl
module testbench;
   import lpn_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;   // path_byte
   logic [1:0]  req_tuser = 0;   // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;      // length, pass, ovf, byte, past_end, fill
   logic        rsp_tuser;      // result_kind
   logic        rsp_tlast;      // is_last_byte
   int          fail_count, pending_count;
   int          items_sent = 0;
   int          rsp_idle = 0;   // cycles left in a receiver idle burst
   bit          calm = 0;       // last part of the run: no idling
   bit          hold_rsp = 0;   // long receiver hold-off

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   lexical_path_normalizer i_dut (.*);

   lpn_checker i_checker (.*);

   // one transaction, with an optional random gap ahead of it
   task automatic send_op(logic [1:0] op, logic [7:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= op; req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_path(string s);
      foreach (s[i]) send_op(OP_APPEND, s[i]);
   endtask

   task automatic fetch_all(int n);
      repeat (n) send_op(OP_FETCH, 8'($urandom));
   endtask

   // random path from a small alphabet biased to slashes and dots
   task automatic send_random_path(int len);
      byte alpha[6] = '{"/", "/", ".", ".", "a", "z"};
      repeat (len) begin
         if ($urandom_range(0, 19) == 0) send_op(OP_APPEND, 8'($urandom_range(1, 255)));
         else send_op(OP_APPEND, alpha[$urandom_range(0, 5)]);
      end
   endtask

   // receiver: random idle bursts, plus one long hold-off
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 0;
      end else if (calm) begin
         rsp_tready <= 1;
      end else if (rsp_idle > 0) begin
         rsp_idle   <= rsp_idle - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_idle   <= $urandom_range(0, 10);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   initial begin
      int k;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty path, fetch while loading, opcode three
      send_op(OP_FETCH, 8'h00);
      send_op(OP_NONE, 8'hFF);
      send_op(OP_FINISH, 8'h00);
      fetch_all(1);
      // dot segments, double slash, leading dot forms, finish twice
      send_path("/a/./b/../c//d"); send_op(OP_FINISH, 8'h00); fetch_all(2);
      send_op(OP_FINISH, 8'h00); fetch_all(1);
      send_path("./x"); send_op(OP_FINISH, 8'h00);
      send_path("../.."); send_op(OP_FINISH, 8'h00); fetch_all(3);
      send_path("ab"); send_op(OP_APPEND, 8'h00); send_op(OP_APPEND, 8'hFF);
      send_op(OP_FINISH, 8'h00); fetch_all(3);

      // receiver holds off for a counted stretch while sender keeps offering fetches
      hold_rsp = 1;
      fork
         fetch_all(4);
         begin
            repeat (60) @(posedge clock);
            hold_rsp = 0;
         end
      join

      // overflow path, also pushing past the segment limit
      for (k = 0; k < 530; k++) send_op(OP_APPEND, (k % 2) ? CH_SLASH : 8'h80 | k[6:0]);
      send_op(OP_FINISH, 8'h00); fetch_all(3);
      send_path("/"); send_op(OP_APPEND, CH_SLASH); send_op(OP_FINISH, 8'h00); fetch_all(2);

      // sender waits for every response
      req_tvalid <= 0;
      do @(posedge clock); while (pending_count != 0);

      while (items_sent < 1850) begin
         if (items_sent > 1600) calm = 1;
         send_random_path($urandom_range(0, 12));
         if ($urandom_range(0, 9) != 0) begin
            send_op(OP_FINISH, 8'h00);
            fetch_all($urandom_range(0, 14));
         end
      end
      send_op(OP_FINISH, 8'h00); fetch_all(2);
      req_tvalid <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
sv/lpn_pkg.sv
sv/lpn_ctrl.sv
sv/lpn_datapath.sv
sv/lexical_path_normalizer.sv
verif/lpn_checker.sv
verif/testbench.sv
